FILE: rtl/cpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped PI speed controller package
// Shared word types, register indexes, fixed-point widths and limits.
// ----------------------------------------------------------------------------
package cpsc_pkg;

	// Width of the wide arithmetic inside the control law.
	localparam int ACC_W   = 36;
	// Integral sum, Q.8, range +-1280000.
	localparam int INT_W   = 22;
	// Stored output, Q.8; it lies between the previous value and the raw sum,
	// or in the hold band, so it stays within the raw sum's range of about +-4.75e9.
	localparam int PREV_W  = 34;
	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int TRACK_W = 20;
	localparam int DRIVE_W = 16;
	localparam int INDEX_W = 8;
	localparam int FRAC_W  = 8;

	typedef logic [INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_SETPOINT = 8'd0;
	localparam cfg_index_t REG_GAIN_P   = 8'd1;
	localparam cfg_index_t REG_GAIN_I   = 8'd2;
	localparam cfg_index_t REG_GAIN_D   = 8'd3;

	localparam logic signed [SPEED_W-1:0] SETPOINT_RST = 16'sd0;
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd2304;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd179;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;

	localparam logic [TRACK_W-1:0] TRACK_THRESHOLD = 20'd4000;
	localparam int ERR_LIMIT = 7000;

	// Limits in Q.8.
	localparam logic signed [ACC_W-1:0] INT_LIMIT  = ACC_W'(5000 * 256);
	localparam logic signed [ACC_W-1:0] SLEW_TIGHT = ACC_W'(5000 * 256);
	localparam logic signed [ACC_W-1:0] SLEW_WIDE  = ACC_W'(8000 * 256);
	localparam logic signed [ACC_W-1:0] HOLD_LOW   = ACC_W'(6000 * 256);
	localparam logic signed [ACC_W-1:0] HOLD_HIGH  = ACC_W'(10000 * 256);
	localparam logic signed [ACC_W-1:0] OUT_LIMIT  = ACC_W'(25000 * 256);

	typedef struct packed {
		logic signed [SPEED_W-1:0] measured_speed;
		logic [TRACK_W-1:0]        track_length;
		logic                      ramp_flag;
		logic                      hold_switch;
	} in_word_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_value;
		logic                      held;
	} out_word_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] setpoint;
		logic [GAIN_W-1:0]         gain_p;
		logic [GAIN_W-1:0]         gain_i;
		logic [GAIN_W-1:0]         gain_d;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [INT_W-1:0]   integral_sum;
		logic signed [PREV_W-1:0]  previous_output;
		logic signed [SPEED_W-1:0] previous_speed;
	} loop_state_t;

endpackage

FILE: rtl/cpsc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed sample channel
// Valid/ready channel carrying one speed sample word per handshake.
// ----------------------------------------------------------------------------
interface cpsc_in_if;
	logic               valid;
	logic               ready;
	cpsc_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cpsc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive result channel
// Valid/ready channel carrying one drive result word per handshake.
// ----------------------------------------------------------------------------
interface cpsc_out_if;
	logic                valid;
	logic                ready;
	cpsc_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cpsc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface cpsc_cfg_if;
	logic                                 valid;
	logic                                 ready;
	cpsc_pkg::cfg_index_t                 index;
	logic [cpsc_pkg::GAIN_W-1:0]          wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/cpsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped PI speed controller datapath
// One pass of the control law: next loop state and the result word.
// ----------------------------------------------------------------------------
module cpsc_datapath (
	input  cpsc_pkg::in_word_t    word,
	input  cpsc_pkg::cfg_regs_t   regs,
	input  cpsc_pkg::loop_state_t cur,
	output cpsc_pkg::loop_state_t nxt,
	output cpsc_pkg::out_word_t   res
);

	localparam int ACC_W = cpsc_pkg::ACC_W;

	logic signed [16:0]      err_full;
	logic                    err_ok;
	logic signed [13:0]      err;
	logic signed [30:0]      prod_i;
	logic signed [30:0]      prod_p;
	logic signed [16:0]      drop;
	logic signed [33:0]      prod_d;
	logic signed [ACC_W-1:0] int_raw;
	logic signed [ACC_W-1:0] int_clamped;
	logic signed [ACC_W-1:0] sum;
	logic signed [ACC_W-1:0] prev_ext;
	logic signed [ACC_W-1:0] limit;
	logic signed [ACC_W-1:0] delta;
	logic signed [ACC_W-1:0] sum_lim;
	logic signed [ACC_W-1:0] held_val;
	logic signed [ACC_W-1:0] out_sat;
	logic signed [ACC_W-1:0] chosen;
	logic signed [ACC_W-1:0] biased;
	logic                    hold;

	always_comb begin
		// Error is zeroed when its magnitude is beyond the trust band.
		err_full = 17'($signed(regs.setpoint)) - 17'($signed(word.measured_speed));
		err_ok = (err_full <= 17'sd7000) && (err_full >= -17'sd7000);
		err = err_ok ? err_full[13:0] : 14'sd0;

		prod_i = $signed({1'b0, regs.gain_i}) * err;
		prod_p = $signed({1'b0, regs.gain_p}) * err;
		drop = 17'($signed(cur.previous_speed)) - 17'($signed(word.measured_speed));
		prod_d = $signed({1'b0, regs.gain_d}) * drop;

		// Anti-windup clamp on the integral.
		int_raw = ACC_W'($signed(cur.integral_sum)) + ACC_W'(prod_i);
		if (int_raw > cpsc_pkg::INT_LIMIT) begin
			int_clamped = cpsc_pkg::INT_LIMIT;
		end else if (int_raw < -cpsc_pkg::INT_LIMIT) begin
			int_clamped = -cpsc_pkg::INT_LIMIT;
		end else begin
			int_clamped = int_raw;
		end

		sum = int_clamped + ACC_W'(prod_p) + ACC_W'(prod_d);

		// Slew limit against the stored output.
		prev_ext = ACC_W'($signed(cur.previous_output));
		limit = (word.track_length > cpsc_pkg::TRACK_THRESHOLD) ?
			cpsc_pkg::SLEW_TIGHT : cpsc_pkg::SLEW_WIDE;
		delta = sum - prev_ext;
		if (delta > limit) begin
			sum_lim = prev_ext + limit;
		end else if (delta < -limit) begin
			sum_lim = prev_ext - limit;
		end else begin
			sum_lim = sum;
		end

		if (prev_ext < cpsc_pkg::HOLD_LOW) begin
			held_val = cpsc_pkg::HOLD_LOW;
		end else if (prev_ext > cpsc_pkg::HOLD_HIGH) begin
			held_val = cpsc_pkg::HOLD_HIGH;
		end else begin
			held_val = prev_ext;
		end

		if (sum_lim > cpsc_pkg::OUT_LIMIT) begin
			out_sat = cpsc_pkg::OUT_LIMIT;
		end else if (sum_lim < -cpsc_pkg::OUT_LIMIT) begin
			out_sat = -cpsc_pkg::OUT_LIMIT;
		end else begin
			out_sat = sum_lim;
		end

		hold = word.ramp_flag & word.hold_switch;
		chosen = hold ? held_val : out_sat;

		// Drop the fraction, truncating toward zero.
		biased = chosen + (chosen[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
		res.drive_value = biased[cpsc_pkg::FRAC_W +: cpsc_pkg::DRIVE_W];
		res.held = hold;

		nxt.integral_sum = int_clamped[cpsc_pkg::INT_W-1:0];
		nxt.previous_output = hold ? held_val[cpsc_pkg::PREV_W-1:0]
			: sum_lim[cpsc_pkg::PREV_W-1:0];
		nxt.previous_speed = hold ? cur.previous_speed : word.measured_speed;
	end

endmodule

FILE: rtl/clamped_pi_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped PI speed controller
// PI(D) speed loop with error gating, integral anti-windup, output slew
// limiting, hold-on-ramp and output saturation, one result per sample.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word
//   sample    in         measured_speed, track_length, ramp_flag, hold_switch
//   result    out        drive_value, held
//   cfg       in         index, wdata (setpoint, gain_p, gain_i, gain_d)
//
// A sample is taken into an input register, and the whole control law is
// evaluated between that register and the result register, so one sample
// can be accepted every cycle while the result word is not stalled; its
// result word is loaded into the result register as soon as that register
// is free or being emptied. The loop state (integral, stored output,
// previous speed) is written on the same edge as the result register, so
// the next sample always sees it. When the result word stalls, an empty
// input register still takes one more sample before sample.ready drops.
// Reset clears the loop state to zero and returns the gains and setpoint to their defaults.
// ----------------------------------------------------------------------------
module clamped_pi_speed_controller (
	input  logic       clk,
	input  logic       arst_n,
	cpsc_in_if.sink    sample,
	cpsc_out_if.source result,
	cpsc_cfg_if.sink   cfg
);

	cpsc_pkg::cfg_regs_t   regs_q;
	cpsc_pkg::loop_state_t state_q;
	cpsc_pkg::loop_state_t state_nxt;
	cpsc_pkg::in_word_t    word_s1;
	logic                  valid_s1;
	cpsc_pkg::out_word_t   out_q;
	cpsc_pkg::out_word_t   out_nxt;
	logic                  out_valid_q;
	logic                  advance;
	logic                  fire;

	// Configuration is always accepted; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.setpoint <= cpsc_pkg::SETPOINT_RST;
			regs_q.gain_p   <= cpsc_pkg::GAIN_P_RST;
			regs_q.gain_i   <= cpsc_pkg::GAIN_I_RST;
			regs_q.gain_d   <= cpsc_pkg::GAIN_D_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cpsc_pkg::REG_SETPOINT: regs_q.setpoint <= $signed(cfg.wdata);
				cpsc_pkg::REG_GAIN_P:   regs_q.gain_p   <= cfg.wdata;
				cpsc_pkg::REG_GAIN_I:   regs_q.gain_i   <= cfg.wdata;
				cpsc_pkg::REG_GAIN_D:   regs_q.gain_d   <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	// The input register moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			word_s1 <= sample.data;
		end
	end

	cpsc_datapath u_datapath (
		.word (word_s1),
		.regs (regs_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (out_nxt)
	);

	// Loop state is part of the behaviour, so it is reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= out_nxt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped PI speed controller testbench
// Drives speed sample words through the controller across several gain and
// setpoint settings, predicts every drive result in step with the accepted
// samples, and checks each returned result word field by field. The sender
// and the receiver idle at random, and in one phase the receiver holds off
// for a long stretch so that the controller backs up into its input.
// ----------------------------------------------------------------------------
module testbench;

	// Fixed-point constants of the control law, all in Q.8 where scaled.
	localparam longint Q8_ONE       = 256;
	localparam longint ERR_GATE     = 7000;
	localparam longint INTEGRAL_MAX = 5000 * Q8_ONE;
	localparam longint SLEW_NARROW  = 5000 * Q8_ONE;
	localparam longint SLEW_BROAD   = 8000 * Q8_ONE;
	localparam longint TRACK_SPLIT  = 4000;
	localparam longint HOLD_MIN     = 6000 * Q8_ONE;
	localparam longint HOLD_MAX     = 10000 * Q8_ONE;
	localparam longint DRIVE_MAX    = 25000 * Q8_ONE;

	// Indexes that address no register; writes to them must change nothing.
	localparam cpsc_pkg::cfg_index_t REG_UNUSED_NEXT = 8'd4;
	localparam cpsc_pkg::cfg_index_t REG_UNUSED_TOP  = 8'hFF;

	localparam int RANDOM_PER_PHASE = 130;
	localparam int LONG_HOLD_CYCLES = 400;
	// Idle time after the last result word before the next phase begins.
	localparam int SETTLE_CYCLES    = 8;
	localparam int CYCLE_LIMIT      = 200000;

	typedef enum int {
		PH_DIRECTED,
		PH_STEADY,
		PH_SPARSE_SEND,
		PH_SLOW_SINK,
		PH_MIXED,
		PH_BACKPRESSURE,
		PH_CLOSING
	} phase_t;

	logic clk;
	logic arst_n;

	cpsc_in_if  sample ();
	cpsc_out_if result ();
	cpsc_cfg_if cfg ();

	clamped_pi_speed_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	// Shadow copy of the registers and of the loop state, as the predictor
	// sees them.
	cpsc_pkg::cfg_regs_t shadow_cfg;
	longint              integral_q8;
	longint              stored_q8;
	longint              prior_speed;

	cpsc_pkg::in_word_t  pending_samples[$];
	cpsc_pkg::out_word_t drive_expected[$];
	cpsc_pkg::out_word_t head_word;

	phase_t phase;
	int     send_idle_pct;
	int     sink_stall_pct;
	int     speed_bias;
	int     hold_cycles;
	int     cycle_count;
	int     errors;
	int     samples_accepted;
	int     results_checked;
	int     held_seen;
	int     input_blocked;
	int     reg_writes;

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	function automatic longint clamp_q8(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// One control tick: updates the shadow loop state and returns the word
	// that the controller must produce for this sample.
	function automatic cpsc_pkg::out_word_t predict_drive(cpsc_pkg::in_word_t w);
		longint              speed;
		longint              err;
		longint              raw_q8;
		longint              slew;
		longint              drive_q8;
		cpsc_pkg::out_word_t r;

		speed = longint'(w.measured_speed);
		err   = longint'(shadow_cfg.setpoint) - speed;
		// A large error is treated as a bad sample and contributes nothing.
		if (err > ERR_GATE || err < -ERR_GATE)
			err = 0;

		// Anti-windup: the integral is clamped after every update, even on hold.
		integral_q8 = clamp_q8(integral_q8 + longint'(shadow_cfg.gain_i) * err,
			-INTEGRAL_MAX, INTEGRAL_MAX);

		raw_q8 = integral_q8 + longint'(shadow_cfg.gain_p) * err
			+ longint'(shadow_cfg.gain_d) * (prior_speed - speed);

		// Slew limit against the last stored output.
		slew = (longint'(w.track_length) > TRACK_SPLIT) ? SLEW_NARROW : SLEW_BROAD;
		if (raw_q8 - stored_q8 > slew)
			raw_q8 = stored_q8 + slew;
		else if (raw_q8 - stored_q8 < -slew)
			raw_q8 = stored_q8 - slew;

		if (w.ramp_flag && w.hold_switch) begin
			// Hold on a ramp: the stored output is pulled into the hold band and
			// kept; the previous speed is left alone.
			stored_q8 = clamp_q8(stored_q8, HOLD_MIN, HOLD_MAX);
			drive_q8  = stored_q8;
			r.held    = 1'b1;
		end else begin
			prior_speed = speed;
			stored_q8   = raw_q8;
			drive_q8    = clamp_q8(raw_q8, -DRIVE_MAX, DRIVE_MAX);
			r.held      = 1'b0;
		end
		// Division on longint truncates toward zero, as the drive value must.
		r.drive_value = 16'(drive_q8 / Q8_ONE);
		return r;
	endfunction

	function automatic cpsc_pkg::in_word_t make_sample(int speed, int track, bit ramp,
			bit hold);
		cpsc_pkg::in_word_t w;

		w.measured_speed = 16'(speed);
		w.track_length   = 20'(track);
		w.ramp_flag      = ramp;
		w.hold_switch    = hold;
		return w;
	endfunction

	// Most samples sit near the setpoint, shifted by a per-phase bias so that
	// the integral winds up against its clamp; the rest span the full range.
	function automatic cpsc_pkg::in_word_t random_sample();
		int speed;
		int track;
		int pick;

		pick = $urandom_range(99);
		if (pick < 75) begin
			speed = int'(shadow_cfg.setpoint) + speed_bias + int'($urandom_range(16000)) - 8000;
			if (speed > 32767)
				speed = 32767;
			if (speed < -32768)
				speed = -32768;
		end else begin
			speed = int'($urandom_range(16'hFFFF)) - 32768;
		end

		pick = $urandom_range(99);
		if (pick < 40)
			track = $urandom_range(4100, 3900);
		else if (pick < 75)
			track = $urandom_range(20000);
		else
			track = $urandom_range(20'hFFFFF);

		return make_sample(speed, track, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endfunction

	// Updates the shadow registers exactly as the controller decodes a write.
	function automatic void apply_reg(cpsc_pkg::cfg_index_t idx,
			logic [cpsc_pkg::GAIN_W-1:0] val);
		case (idx)
			cpsc_pkg::REG_SETPOINT: begin
				shadow_cfg.setpoint = val;
			end
			cpsc_pkg::REG_GAIN_P: begin
				shadow_cfg.gain_p = val;
			end
			cpsc_pkg::REG_GAIN_I: begin
				shadow_cfg.gain_i = val;
			end
			cpsc_pkg::REG_GAIN_D: begin
				shadow_cfg.gain_d = val;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic write_reg(cpsc_pkg::cfg_index_t idx, logic [cpsc_pkg::GAIN_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		apply_reg(idx, val);
		reg_writes++;
		cfg.valid <= 1'b0;
	endtask

	// Waits until every pending sample has gone in and every result word has
	// come back, then lets the pipeline settle.
	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample.valid || drive_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_phase(phase_t ph, int send_pct, int sink_pct);
		@(negedge clk);
		phase          = ph;
		send_idle_pct  = send_pct;
		sink_stall_pct = sink_pct;
		speed_bias     = int'($urandom_range(6000)) - 3000;
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			pending_samples.push_back(random_sample());
		wait_drained();
	endtask

	// Sample driver: when the channel is free, offers the next pending word unless
	// it idles at random, and predicts each word at the edge where it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
		end else begin
			if (sample.valid && sample.ready) begin
				drive_expected.push_back(predict_drive(sample.data));
				samples_accepted++;
			end
			if (sample.valid && !sample.ready)
				input_blocked++;
			if (!sample.valid || sample.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample.valid <= 1'b1;
					sample.data  <= pending_samples.pop_front();
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the receiver, counted here so that it runs on its own
	// while the driver keeps offering words.
	always @(posedge clk) begin
		if (phase == PH_BACKPRESSURE && hold_cycles < LONG_HOLD_CYCLES)
			hold_cycles <= hold_cycles + 1;
	end

	// Result monitor: checks each accepted result word against the oldest
	// prediction, then decides whether to be ready on the next edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (drive_expected.size() == 0) begin
					$display("%0t ns: result word with nothing expected: drive_value %0d held %0b",
						$time, result.data.drive_value, result.data.held);
					errors++;
				end else begin
					head_word = drive_expected.pop_front();
					if (result.data.drive_value !== head_word.drive_value) begin
						$display("%0t ns: drive_value expected %0d, got %0d",
							$time, head_word.drive_value, result.data.drive_value);
						errors++;
					end
					if (result.data.held !== head_word.held) begin
						$display("%0t ns: held expected %0b, got %0b",
							$time, head_word.held, result.data.held);
						errors++;
					end
					if (head_word.held)
						held_seen++;
				end
				results_checked++;
			end
			if (phase == PH_BACKPRESSURE && hold_cycles < LONG_HOLD_CYCLES)
				result.ready <= 1'b0;
			else
				result.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		sample.valid     = 1'b0;
		sample.data      = '0;
		result.ready     = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = cpsc_pkg::REG_SETPOINT;
		cfg.wdata        = '0;
		phase            = PH_DIRECTED;
		send_idle_pct    = 0;
		sink_stall_pct   = 0;
		speed_bias       = 0;
		hold_cycles      = 0;
		cycle_count      = 0;
		errors           = 0;
		samples_accepted = 0;
		results_checked  = 0;
		held_seen        = 0;
		input_blocked    = 0;
		reg_writes       = 0;

		// The registers come out of reset at their defaults and the loop state
		// at zero; the first phase runs on those without any write.
		shadow_cfg.setpoint = cpsc_pkg::SETPOINT_RST;
		shadow_cfg.gain_p   = cpsc_pkg::GAIN_P_RST;
		shadow_cfg.gain_i   = cpsc_pkg::GAIN_I_RST;
		shadow_cfg.gain_d   = cpsc_pkg::GAIN_D_RST;
		integral_q8         = 0;
		stored_q8           = 0;
		prior_speed         = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: error at and just past the gate, the speed extremes,
		// the slew threshold either side, both bit patterns of every field, and
		// hold with and without the switch, including holds back to back.
		@(negedge clk);
		pending_samples.push_back(make_sample(0, 0, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-7000, 4000, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(7000, 4001, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-7001, int'(20'hFFFFF), 1'b0, 1'b0));
		pending_samples.push_back(make_sample(7001, 0, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(32767, 3999, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-32768, 4001, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-5000, 0, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-5000, 0, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-5000, 0, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(-6500, 4001, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(100, 0, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(200, 0, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(300, 0, 1'b1, 1'b0));
		pending_samples.push_back(make_sample(-300, 0, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(6900, 4001, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(6900, 4001, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(0, 0, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(int'(16'h5555), int'(20'h55555), 1'b0, 1'b1));
		pending_samples.push_back(make_sample(int'(16'hAAAA) - 65536, int'(20'hAAAAA),
			1'b1, 1'b0));
		pending_samples.push_back(make_sample(2000, 4000, 1'b0, 1'b0));
		wait_drained();

		// Moderate gains with some derivative action, plus writes to indexes
		// that hold no register.
		write_reg(cpsc_pkg::REG_SETPOINT, 16'd1000);
		write_reg(cpsc_pkg::REG_GAIN_D, 16'd512);
		write_reg(REG_UNUSED_NEXT, 16'hFFFF);
		write_reg(REG_UNUSED_TOP, 16'h1234);
		run_random_phase(PH_STEADY, 0, 0);

		// Most negative setpoint, all gains at their top.
		write_reg(cpsc_pkg::REG_SETPOINT, 16'h8000);
		write_reg(cpsc_pkg::REG_GAIN_P, 16'hFFFF);
		write_reg(cpsc_pkg::REG_GAIN_I, 16'hFFFF);
		write_reg(cpsc_pkg::REG_GAIN_D, 16'hFFFF);
		run_random_phase(PH_SPARSE_SEND, 60, 0);

		// Most positive setpoint, all gains zero.
		write_reg(cpsc_pkg::REG_SETPOINT, 16'h7FFF);
		write_reg(cpsc_pkg::REG_GAIN_P, 16'h0000);
		write_reg(cpsc_pkg::REG_GAIN_I, 16'h0000);
		write_reg(cpsc_pkg::REG_GAIN_D, 16'h0000);
		run_random_phase(PH_SLOW_SINK, 0, 60);

		write_reg(cpsc_pkg::REG_SETPOINT, 16'($urandom_range(4000)) - 16'd2000);
		write_reg(cpsc_pkg::REG_GAIN_P, 16'($urandom_range(16'hFFFF)));
		write_reg(cpsc_pkg::REG_GAIN_I, 16'($urandom_range(4096)));
		write_reg(cpsc_pkg::REG_GAIN_D, 16'($urandom_range(2048)));
		run_random_phase(PH_MIXED, 19, 19);

		// The receiver holds off at the start of this phase while the driver
		// keeps offering, so the controller fills and drops sample.ready.
		write_reg(cpsc_pkg::REG_SETPOINT, 16'd0);
		write_reg(cpsc_pkg::REG_GAIN_P, 16'hFFFF);
		write_reg(cpsc_pkg::REG_GAIN_I, 16'd0);
		write_reg(cpsc_pkg::REG_GAIN_D, 16'hFFFF);
		run_random_phase(PH_BACKPRESSURE, 0, 19);

		write_reg(cpsc_pkg::REG_SETPOINT, 16'($urandom_range(16'hFFFF)));
		write_reg(cpsc_pkg::REG_GAIN_P, 16'($urandom_range(8192)));
		write_reg(cpsc_pkg::REG_GAIN_I, 16'($urandom_range(1024)));
		write_reg(cpsc_pkg::REG_GAIN_D, 16'($urandom_range(16'hFFFF)));
		run_random_phase(PH_CLOSING, 0, 0);

		$display("Checked %0d result words for %0d samples, %0d of them holds, over %0d writes",
			results_checked, samples_accepted, held_seen, reg_writes);
		$display("Sample input was held back by the controller for %0d cycles", input_blocked);
		if (errors == 0 && drive_expected.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/cpsc_pkg.sv
rtl/cpsc_in_if.sv
rtl/cpsc_out_if.sv
rtl/cpsc_cfg_if.sv
rtl/cpsc_datapath.sv
rtl/clamped_pi_speed_controller.sv
verif/testbench.sv
